[hw/rtl/volume_weighted_moving_average_top_defines.svh]
// Assertion helpers for the assertions of the top module
`ifndef VOLUME_WEIGHTED_MOVING_AVERAGE_TOP_DEFINES_SVH
`define VOLUME_WEIGHTED_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define VWMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define VWMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vwma_pkg.sv]
package vwma_pkg;

    localparam int PRICE_W   = 24;
    localparam int VOL_W     = 24;
    localparam int PROD_W    = PRICE_W + VOL_W;
    localparam int AVG_W     = 24;
    localparam int LEN_CFG_W = 9;
    localparam int STEP_W    = $clog2(AVG_W);

    localparam logic [LEN_CFG_W-1:0] LEN_RESET = LEN_CFG_W'(20);

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [VOL_W-1:0]  vol;
    } t_ring_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[hw/rtl/volume_weighted_moving_average_top.sv]
// Channel   Direction  Payload
// s_axis    in         tdata[47:0]: price, volume
// m_axis    out        tdata[23:0]: average; tuser: valid_res
// cfg       in         i_cfg_wr_data[8:0]: window_len
//
// Each item runs, from one accept to the next, through ring read, multiply,
// sum update, 24 steps of the restoring divider, the done strobe and the
// output load. Warm-up items skip the divider.
// Reset is synchronous, active low; the ring holds no reset value.
// A waiting result sits in the output register while the next item is taken.
`include "volume_weighted_moving_average_top_defines.svh"

module volume_weighted_moving_average_top
    import vwma_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [47:0]            s_axis_tdata,   // price[23:0], volume[47:24]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [23:0]            m_axis_tdata,   // average[23:0]
    output logic                   m_axis_tuser,   // valid_res[0]
    input  logic                   i_cfg_wr_en,
    input  logic [LEN_CFG_W-1:0]   i_cfg_wr_data
);

    localparam int CW    = $clog2(MAX_WINDOW);
    localparam int IDX_W = CW;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int PS_W  = PROD_W + CW;
    localparam int VS_W  = VOL_W + CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    t_ring_entry r_ring [MAX_WINDOW];
    t_ring_entry r_ring_rd;

    logic [2:0]           r_state;
    logic [LEN_CFG_W-1:0] r_win_len;
    logic [IDX_W-1:0]     r_slot;
    logic [LEN_W-1:0]     r_fill;
    logic [PS_W-1:0]      r_psum;
    logic [VS_W-1:0]      r_vsum;
    logic                 r_full_pre;
    logic [PRICE_W-1:0]   r_price;
    logic [VOL_W-1:0]     r_vol;
    logic [PROD_W-1:0]    r_prod;
    logic [AVG_W-1:0]     r_res_avg;
    logic                 r_res_valid;
    logic                 r_out_valid;
    logic [AVG_W-1:0]     r_out_avg;
    logic                 r_out_flag;

    logic [31:0]          w_len_raw;
    logic [31:0]          w_len;
    logic [31:0]          w_slot_inc;
    logic [31:0]          w_fill_inc;
    logic                 w_full_pre;
    logic                 w_full_now;
    logic                 w_in_acc;
    logic                 w_out_load;
    logic [PS_W-1:0]      n_psum;
    logic [VS_W-1:0]      n_vsum;
    logic [IDX_W-1:0]     n_slot;
    logic [LEN_W-1:0]     n_fill;
    logic [VOL_W-1:0]     w_vol_in;
    logic                 w_div_start;
    t_div_status          w_div_st;
    logic [AVG_W-1:0]     w_div_quot;

    always_comb begin
        w_len_raw = 32'(r_win_len);
        w_len     = w_len_raw;
        if (w_len_raw == 32'd0) begin
            w_len = 32'd1;
        end
        if (w_len_raw > 32'(MAX_WINDOW)) begin
            w_len = 32'(MAX_WINDOW);
        end
    end

    assign w_slot_inc = 32'(r_slot) + 32'd1;
    assign w_fill_inc = 32'(r_fill) + 32'd1;
    assign w_full_pre = (32'(r_fill) >= w_len);
    assign w_full_now = r_full_pre || (w_fill_inc >= w_len);
    assign n_slot     = (w_slot_inc >= w_len) ? '0 : w_slot_inc[IDX_W-1:0];
    assign n_fill     = r_full_pre ? r_fill : w_fill_inc[LEN_W-1:0];
    assign n_psum     = r_psum + {{CW{1'b0}}, r_prod};
    assign n_vsum     = r_vsum + {{CW{1'b0}}, r_vol};

    assign w_vol_in    = (s_axis_tdata[47:24] == '0) ? VOL_W'(1) : s_axis_tdata[47:24];
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_load  = (r_state == S_PUT) && (!r_out_valid || m_axis_tready);
    assign w_div_start = (r_state == S_SUM) && w_full_now;

    vwma_div #(
        .DIVS_W (VS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_psum),
        .i_divisor  (n_vsum),
        .o_status   (w_div_st),
        .o_quot     (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_len   <= LEN_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_psum      <= '0;
            r_vsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win_len <= i_cfg_wr_data;
                r_slot    <= '0;
                r_fill    <= '0;
                r_psum    <= '0;
                r_vsum    <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_full_pre) begin
                        r_psum <= r_psum - {{CW{1'b0}}, r_ring_rd.prod};
                        r_vsum <= r_vsum - {{CW{1'b0}}, r_ring_rd.vol};
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_psum  <= n_psum;
                    r_vsum  <= n_vsum;
                    r_slot  <= n_slot;
                    r_fill  <= n_fill;
                    r_state <= w_full_now ? S_DIV : S_PUT;
                end
                S_DIV: begin
                    if (w_div_st.done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_price    <= s_axis_tdata[23:0];
            r_vol      <= w_vol_in;
            r_ring_rd  <= r_ring[r_slot];
            r_full_pre <= w_full_pre;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_price * r_vol;
        end
        if (r_state == S_SUM) begin
            r_ring[r_slot] <= '{prod: r_prod, vol: r_vol};
            r_res_avg      <= '0;
            r_res_valid    <= w_full_now;
        end
        if ((r_state == S_DIV) && w_div_st.done) begin
            r_res_avg <= w_div_quot;
        end
        if (w_out_load) begin
            r_out_avg  <= r_res_avg;
            r_out_flag <= r_res_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_avg;
    assign m_axis_tuser  = r_out_flag;

    `VWMA_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV), (r_vsum != '0), "division by an empty volume sum")

    `VWMA_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, 1'b1, ((32'(r_slot) < w_len) && (32'(r_fill) <= w_len)), "ring slot or fill count beyond window")

    `VWMA_ASSERT_NOW(a_warm_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tuser), (m_axis_tdata == '0), "warm-up item with non-zero average")

    `VWMA_ASSERT_NEXT(a_div_idle, i_clk, i_rst_n, (w_div_st.done), (!w_div_st.busy && (r_state == S_PUT)), "divider finished outside the divide state")

endmodule

[hw/rtl/vwma_div.sv]
module vwma_div
    import vwma_pkg::*;
#(
    parameter int DIVS_W = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVS_W+AVG_W-1:0]   i_dividend,
    input  logic [DIVS_W-1:0]         i_divisor,
    output t_div_status               o_status,
    output logic [AVG_W-1:0]          o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVS_W:0]   r_rem;
    logic [AVG_W-1:0]  r_q;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   w_shift;
    logic [DIVS_W+1:0] w_diff;
    logic              w_qbit;

    assign w_shift = {r_rem[DIVS_W-1:0], r_q[AVG_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_qbit  = ~w_diff[DIVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(AVG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
        end
    end

    // quotient fits AVG_W bits, so the upper dividend part starts below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend[DIVS_W+AVG_W-1:AVG_W]};
            r_q   <= i_dividend[AVG_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[DIVS_W:0] : w_shift;
            r_q   <= {r_q[AVG_W-2:0], w_qbit};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_q;

endmodule

[tb/sv/volume_weighted_moving_average_top_tb.sv]
`timescale 1ns / 100ps

module volume_weighted_moving_average_top_tb
    import vwma_pkg::*;
();

    localparam int MAX_WINDOW   = 256;
    localparam int HIST_W       = $clog2(MAX_WINDOW);
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int N_ROWS       = 24;
    localparam int N_PHASES     = 12;

    typedef enum bit {ROW_BAR, ROW_LEN} t_row_op;

    typedef struct packed {
        t_row_op                op;
        logic [LEN_CFG_W-1:0]   len;
        logic [PRICE_W-1:0]     price;
        logic [VOL_W-1:0]       vol;
        bit                     fixed;
        logic [AVG_W-1:0]       avg;
        logic                   valid;
    } t_bar_row;

    typedef struct packed {
        logic [AVG_W-1:0]   avg;
        logic               valid;
    } t_vwma_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [47:0]            s_axis_tdata;   // price[23:0], volume[47:24]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [23:0]            m_axis_tdata;   // average[23:0]
    logic                   m_axis_tuser;   // valid_res[0]
    logic                   i_cfg_wr_en;
    logic [LEN_CFG_W-1:0]   i_cfg_wr_data;

    // predictor state
    logic [PROD_W-1:0]      prod_hist [MAX_WINDOW];
    logic [VOL_W-1:0]       vol_hist [MAX_WINDOW];
    logic [55:0]            pv_total;
    logic [31:0]            vol_total;
    int                     next_slot;
    int                     bars_held;
    logic [LEN_CFG_W-1:0]   win_cfg;

    t_vwma_result           average_q [$];
    t_bar_row               bar_table [N_ROWS];
    int                     fails = 0;
    int                     cycles = 0;
    bit                     send_quiet;
    bit                     take_quiet;

    volume_weighted_moving_average_top #(
        .MAX_WINDOW (MAX_WINDOW)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** volume_weighted_moving_average_top: FAILED **");
            $finish;
        end
    end

    function automatic void restart_window(input logic [LEN_CFG_W-1:0] len);
        win_cfg   = len;
        pv_total  = '0;
        vol_total = '0;
        next_slot = 0;
        bars_held = 0;
    endfunction

    function automatic t_vwma_result predict_average(input logic [PRICE_W-1:0] price,
                                                     input logic [VOL_W-1:0] vol);
        int                 len;
        int                 slot;
        logic [VOL_W-1:0]   v;
        logic [PROD_W-1:0]  prod;
        t_vwma_result       res;
        len = (win_cfg == 0) ? 1 : (win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg);
        v = (vol == '0) ? VOL_W'(1) : vol;
        prod = {{VOL_W{1'b0}}, price} * {{PRICE_W{1'b0}}, v};
        slot = (next_slot >= len) ? 0 : next_slot;
        if (bars_held >= len) begin
            pv_total  = pv_total - 56'(prod_hist[HIST_W'(slot)]);
            vol_total = vol_total - 32'(vol_hist[HIST_W'(slot)]);
        end
        prod_hist[HIST_W'(slot)] = prod;
        vol_hist[HIST_W'(slot)]  = v;
        pv_total  = pv_total + 56'(prod);
        vol_total = vol_total + 32'(v);
        slot++;
        next_slot = (slot >= len) ? 0 : slot;
        if (bars_held < len)
            bars_held++;
        res.valid = (bars_held >= len);
        res.avg   = (res.valid && vol_total != 0) ? AVG_W'(pv_total / 56'(vol_total)) : '0;
        return res;
    endfunction

    function automatic int pick_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic logic [PRICE_W-1:0] rand_price();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PRICE_W'($urandom_range(0, 255));
            default: return PRICE_W'($urandom);
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] rand_volume();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VOL_W'(1);
            2: return '1;
            3, 4, 5: return VOL_W'($urandom_range(1, 1000));
            default: return VOL_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        if (fails < 40)
            $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        fails++;
    endtask

    // hold the sender until every pending result has been taken
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (average_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_CFG_W-1:0] len);
        settle_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        restart_window(len);
    endtask

    task automatic send_bar(input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] vol,
                            input bit fixed, input t_vwma_result want);
        int             gap;
        t_vwma_result   pred;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vol, price};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        pred = predict_average(price, vol);
        average_q.push_back(fixed ? want : pred);
    endtask

    initial begin
        int         stall;
        t_vwma_result want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = pick_wait(take_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1)
                @(posedge i_clk);
            if (average_q.size() == 0) begin
                report_mismatch("unexpected result, average", m_axis_tdata, '0);
            end else begin
                want = average_q.pop_front();
                if (m_axis_tdata !== want.avg)
                    report_mismatch("average", m_axis_tdata, want.avg);
                if (m_axis_tuser !== want.valid)
                    report_mismatch("valid_res", 24'(m_axis_tuser), 24'(want.valid));
            end
        end
    end

    initial begin
        int             phase_len [N_PHASES];
        int             phase_items [N_PHASES];
        t_vwma_result   want;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        restart_window(LEN_RESET);
        bar_table = '{
            '{ROW_BAR, 9'd0,   24'hFFFFFF, 24'h000000, 1'b1, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 1'b0},
            '{ROW_LEN, 9'd1,   24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h123456, 24'h000007, 1'b1, 24'h123456, 1'b1},
            '{ROW_BAR, 9'd0,   24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1},
            '{ROW_BAR, 9'd0,   24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 1'b1},
            '{ROW_BAR, 9'd0,   24'hFFFFFF, 24'h000000, 1'b1, 24'hFFFFFF, 1'b1},
            '{ROW_LEN, 9'd0,   24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'hABCDEF, 24'h000005, 1'b1, 24'hABCDEF, 1'b1},
            '{ROW_BAR, 9'd0,   24'h000100, 24'h000000, 1'b1, 24'h000100, 1'b1},
            '{ROW_LEN, 9'd2,   24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'd100,    24'd1,      1'b1, 24'd0,      1'b0},
            '{ROW_BAR, 9'd0,   24'd300,    24'd3,      1'b1, 24'd250,    1'b1},
            '{ROW_BAR, 9'd0,   24'hFFFFFF, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h000000, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
            '{ROW_LEN, 9'd511, 24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'd55,     24'd9,      1'b1, 24'd0,      1'b0},
            '{ROW_LEN, 9'd3,   24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h800000, 24'h000010, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h000001, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h7FFFFF, 24'h000002, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'h123456, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_LEN, 9'd257, 24'h000000, 24'h000000, 1'b0, 24'h000000, 1'b0},
            '{ROW_BAR, 9'd0,   24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'h000000, 1'b0}
        };
        phase_len   = '{256, 511, 1, 0, 2, 3, $urandom_range(4, 64), $urandom_range(4, 64),
                        $urandom_range(4, 64), $urandom_range(4, 64),
                        $urandom_range(65, 255), 20};
        phase_items = '{300, 270, 80, 40, 80, 80, 80, 80, 80, 80, 100, 80};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (bar_table[r]) begin
            if (bar_table[r].op == ROW_LEN) begin
                write_len(bar_table[r].len);
            end else begin
                want.avg   = bar_table[r].avg;
                want.valid = bar_table[r].valid;
                send_bar(bar_table[r].price, bar_table[r].vol, bar_table[r].fixed, want);
            end
        end

        want = '0;
        for (int p = 0; p < N_PHASES; p++) begin
            write_len(LEN_CFG_W'(phase_len[p]));
            for (int n = 0; n < phase_items[p]; n++) begin
                if (n == phase_items[p] / 2 || $urandom_range(0, 99) == 0)
                    settle_idle();
                send_bar(rand_price(), rand_volume(), 1'b0, want);
            end
        end

        settle_idle();
        if (fails == 0) begin
            $display("** volume_weighted_moving_average_top: PASSED **");
        end else begin
            $display("** volume_weighted_moving_average_top: FAILED **");
        end
        $finish;
    end

endmodule
